// ===== rtl/gocmv_pkg.sv =====
package gocmv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COMP_BITS   = SAMPLE_BITS + 1;
	localparam int LANES       = 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COMP_BITS-1:0]   comp_t;

	// per-lane controls driven by the top level
	typedef struct packed {
		logic acc;     // add sample into the channel sum
		logic clr;     // start sum from zero (restart)
		logic en1;     // load input stage
		logic en2;     // advance to multiply stage
		logic en3;     // advance to subtract stage
		logic ofs_ld;  // calibration done: take new offset
	} lane_ctl_t;

endpackage

// ===== rtl/gocmv_ifs.sv =====
interface gocmv_in_if;
	logic                valid;
	logic                ready;
	gocmv_pkg::sample_t  sample_a;
	gocmv_pkg::sample_t  sample_b;
	gocmv_pkg::sample_t  sample_c;
	logic                restart;

	modport source (output valid, sample_a, sample_b, sample_c, restart, input ready);
	modport sink   (input valid, sample_a, sample_b, sample_c, restart, output ready);
endinterface

interface gocmv_out_if;
	logic              valid;
	logic              ready;
	gocmv_pkg::comp_t  comp_a;
	gocmv_pkg::comp_t  comp_b;
	gocmv_pkg::comp_t  comp_c;
	gocmv_pkg::comp_t  voted;

	modport source (output valid, comp_a, comp_b, comp_c, voted, input ready);
	modport sink   (input valid, comp_a, comp_b, comp_c, voted, output ready);
endinterface

// ===== rtl/gocmv_lane.sv =====
// One channel: running sum, offset by reciprocal multiply, offset subtract.
module gocmv_lane #(
	parameter int CAL_SAMPLES = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gocmv_pkg::lane_ctl_t ctl,
	input  gocmv_pkg::sample_t   sample,
	output gocmv_pkg::comp_t     comp_s3
);

	localparam int SB     = gocmv_pkg::SAMPLE_BITS;
	localparam int CB     = gocmv_pkg::COMP_BITS;
	localparam int SUM_W  = SB + $clog2(CAL_SAMPLES) + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int SHIFT  = MAG_W + $clog2(CAL_SAMPLES);
	localparam int RCP_W  = MAG_W + 1;
	localparam int PROD_W = MAG_W + RCP_W;
	// ceil(2^SHIFT / CAL_SAMPLES): exact floor quotient for any magnitude below 2^MAG_W
	localparam longint unsigned RCP_FULL =
		((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / CAL_SAMPLES;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]        sum_abs;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       prod_c;
	logic [PROD_W-1:0]       prod_s2;
	logic                    neg_s2;
	logic [CB-1:0]           quot;
	logic [CB-1:0]           ofs_wide;
	gocmv_pkg::sample_t      smp_s1;
	gocmv_pkg::sample_t      smp_s2;
	gocmv_pkg::sample_t      offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= (ctl.clr ? SUM_W'(0) : sum_q)
				+ {{(SUM_W-SB){sample[SB-1]}}, sample};
		end
	end

	assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign mag     = sum_abs[MAG_W-1:0];
	assign prod_c  = {{RCP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RCP};

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			smp_s1 <= sample;
		end
		if (ctl.en2) begin
			smp_s2  <= smp_s1;
			prod_s2 <= prod_c;
			neg_s2  <= sum_q[SUM_W-1];
		end
	end

	// truncate toward zero: divide the magnitude, then restore the sign
	assign quot     = prod_s2[SHIFT +: CB];
	assign ofs_wide = neg_s2 ? (~quot + CB'(1)) : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (ctl.ofs_ld) begin
			offset_q <= ofs_wide[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			comp_s3 <= {smp_s2[SB-1], smp_s2} - {offset_q[SB-1], offset_q};
		end
	end

endmodule

// ===== rtl/gocmv_median.sv =====
// Merge stage: median of the three lane results, output register.
module gocmv_median (
	input  logic             clk,
	input  logic             en,
	input  gocmv_pkg::comp_t a,
	input  gocmv_pkg::comp_t b,
	input  gocmv_pkg::comp_t c,
	output gocmv_pkg::comp_t a_q,
	output gocmv_pkg::comp_t b_q,
	output gocmv_pkg::comp_t c_q,
	output gocmv_pkg::comp_t med_q
);

	logic             ab_lt;
	gocmv_pkg::comp_t lo1;
	gocmv_pkg::comp_t hi1;
	gocmv_pkg::comp_t lo2;
	gocmv_pkg::comp_t med;

	// max(min(a,b), min(max(a,b),c)); ties fall out as the shared value
	assign ab_lt = a < b;
	assign lo1   = ab_lt ? a : b;
	assign hi1   = ab_lt ? b : a;
	assign lo2   = (hi1 < c) ? hi1 : c;
	assign med   = (lo1 > lo2) ? lo1 : lo2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_q   <= a;
			b_q   <= b;
			c_q   <= c;
			med_q <= med;
		end
	end

endmodule

// ===== rtl/gyro_offset_calibrate_median_vote_core.sv =====
// Channel   Dir  Payload                                  Note
// samples   in   sample_a/b/c (16b signed), restart       one triple per request
// results   out  comp_a/b/c, voted (17b signed)           only for calibrated triples
//
// One request per cycle sustained while results.ready is high; a result passes the
// input register, reciprocal multiply, offset subtract and median + output register.
// The first CAL_SAMPLES requests after reset or a restart give no result.
// Reset clears sums, count, offsets and all stage valids; no clearing pass.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and samples.ready stays high while results.ready is low until all four fill.
module gyro_offset_calibrate_median_vote_core #(
	parameter int CAL_SAMPLES = 20
) (
	input logic         clk,
	input logic         arst_n,
	gocmv_in_if.sink    samples,
	gocmv_out_if.source results
);

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int NL    = gocmv_pkg::LANES;

	// calibration control
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] cnt_nxt;
	logic             calibrated_q;
	logic             cal_eff;
	logic             cal_done;
	logic             accept;

	// stage valids and per-request flags
	logic v1_s1, res_s1, div_s1;
	logic v2_s2, res_s2, div_s2;
	logic v3_s3;
	logic v4_s4;
	logic en1, en2, en3, en4;

	gocmv_pkg::lane_ctl_t ctl;
	gocmv_pkg::sample_t   lane_in   [NL];
	gocmv_pkg::comp_t     lane_comp [NL];

	// ready chain: a stage loads when empty or when it moves on
	assign en4 = !v4_s4 || results.ready;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;

	assign samples.ready = en1;
	assign accept        = samples.valid && en1;

	// restart drops the calibrated flag for this very request
	assign cal_eff  = samples.restart ? 1'b0 : calibrated_q;
	assign cnt_base = samples.restart ? CNT_W'(0) : cnt_q;
	assign cnt_nxt  = cnt_base + CNT_W'(1);
	assign cal_done = (cnt_nxt == CNT_W'(CAL_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			calibrated_q <= 1'b0;
		end else if (accept && !cal_eff) begin
			cnt_q        <= cnt_nxt;
			calibrated_q <= cal_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1  <= 1'b0;
			res_s1 <= 1'b0;
			div_s1 <= 1'b0;
			v2_s2  <= 1'b0;
			res_s2 <= 1'b0;
			div_s2 <= 1'b0;
			v3_s3  <= 1'b0;
			v4_s4  <= 1'b0;
		end else begin
			if (en1) begin
				v1_s1  <= samples.valid;
				res_s1 <= cal_eff;
				div_s1 <= !cal_eff && cal_done;
			end
			if (en2) begin
				v2_s2  <= v1_s1;
				res_s2 <= res_s1;
				div_s2 <= div_s1;
			end
			// calibration requests end here; only results go on
			if (en3) begin
				v3_s3 <= v2_s2 && res_s2;
			end
			if (en4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	// the request that closes calibration loads the offsets as it passes the
	// subtract stage, so requests ahead of it still see the old offsets
	assign ctl.acc    = accept && !cal_eff;
	assign ctl.clr    = samples.restart;
	assign ctl.en1    = en1;
	assign ctl.en2    = en2;
	assign ctl.en3    = en3;
	assign ctl.ofs_ld = en3 && v2_s2 && div_s2;

	assign lane_in[0] = samples.sample_a;
	assign lane_in[1] = samples.sample_b;
	assign lane_in[2] = samples.sample_c;

	for (genvar i = 0; i < NL; i++) begin : g_lane
		gocmv_lane #(
			.CAL_SAMPLES(CAL_SAMPLES)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sample  (lane_in[i]),
			.comp_s3 (lane_comp[i])
		);
	end

	gocmv_median u_median (
		.clk   (clk),
		.en    (en4),
		.a     (lane_comp[0]),
		.b     (lane_comp[1]),
		.c     (lane_comp[2]),
		.a_q   (results.comp_a),
		.b_q   (results.comp_b),
		.c_q   (results.comp_c),
		.med_q (results.voted)
	);

	assign results.valid = v4_s4;

endmodule

// ===== sim/gyro_offset_calibrate_median_vote_core_tb.sv =====
module gyro_offset_calibrate_median_vote_core_tb;

	localparam int CAL_N       = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 37;
	localparam int RAND_ITEMS  = 2000;
	localparam int DRAIN_WAIT  = 12;    // drain margin beyond the four-stage pipeline

	// Offset tracker and median predictor. Requests are noted in order of
	// acceptance; each calibrated one queues the compensated triple and its vote.
	class vote_scoreboard;
		typedef struct {
			gocmv_pkg::comp_t a;
			gocmv_pkg::comp_t b;
			gocmv_pkg::comp_t c;
			gocmv_pkg::comp_t vote;
		} vote_t;

		int    sums[3];
		int    offsets[3];
		int    count;
		bit    calibrated;
		vote_t pending_votes[$];
		int    errors;

		function new();
			for (int k = 0; k < 3; k++) begin
				sums[k]    = 0;
				offsets[k] = 0;
			end
			count      = 0;
			calibrated = 1'b0;
			errors     = 0;
		endfunction

		function int median_of(int x, int y, int z);
			int lo_xy;
			int hi_xy;
			int lo_hz;
			lo_xy = (x < y) ? x : y;
			hi_xy = (x > y) ? x : y;
			lo_hz = (hi_xy < z) ? hi_xy : z;
			return (lo_xy > lo_hz) ? lo_xy : lo_hz;
		endfunction

		function void note_request(gocmv_pkg::sample_t a, gocmv_pkg::sample_t b,
			gocmv_pkg::sample_t c, logic restart);
			int    s[3];
			int    d[3];
			vote_t r;
			s[0] = a;
			s[1] = b;
			s[2] = c;
			if (restart) begin
				for (int k = 0; k < 3; k++)
					sums[k] = 0;
				count      = 0;
				calibrated = 1'b0;
			end
			if (!calibrated) begin
				for (int k = 0; k < 3; k++)
					sums[k] += s[k];
				count++;
				if (count >= CAL_N) begin
					// int division truncates toward zero, as the offset must
					for (int k = 0; k < 3; k++)
						offsets[k] = sums[k] / CAL_N;
					calibrated = 1'b1;
				end
				return;
			end
			for (int k = 0; k < 3; k++)
				d[k] = s[k] - offsets[k];
			r.a    = gocmv_pkg::comp_t'(d[0]);
			r.b    = gocmv_pkg::comp_t'(d[1]);
			r.c    = gocmv_pkg::comp_t'(d[2]);
			r.vote = gocmv_pkg::comp_t'(median_of(d[0], d[1], d[2]));
			pending_votes.push_back(r);
		endfunction

		function void check_result(gocmv_pkg::comp_t a, gocmv_pkg::comp_t b,
			gocmv_pkg::comp_t c, gocmv_pkg::comp_t vote);
			vote_t r;
			if (pending_votes.size() == 0) begin
				$error("unexpected result: comp_a %0d comp_b %0d comp_c %0d voted %0d",
					a, b, c, vote);
				errors++;
				return;
			end
			r = pending_votes.pop_front();
			if (a !== r.a) begin
				$error("comp_a mismatch: expected %0d actual %0d", r.a, a);
				errors++;
			end
			if (b !== r.b) begin
				$error("comp_b mismatch: expected %0d actual %0d", r.b, b);
				errors++;
			end
			if (c !== r.c) begin
				$error("comp_c mismatch: expected %0d actual %0d", r.c, c);
				errors++;
			end
			if (vote !== r.vote) begin
				$error("voted mismatch: expected %0d actual %0d", r.vote, vote);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_votes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;          // both sides stop idling while set
	int   cycle_count;

	vote_scoreboard sb = new();

	gocmv_in_if  samp_if();
	gocmv_out_if res_if();

	gyro_offset_calibrate_median_vote_core #(
		.CAL_SAMPLES(CAL_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samp_if),
		.results(res_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run with both sides idling.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Result side: ready changes at the falling edge, idles at random
	// except during the quiet stretch.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Results are sampled at the rising edge, before the block's flops update.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.comp_a, res_if.comp_b, res_if.comp_c, res_if.voted);
	end

	// One request: optional idle cycles, then hold valid until taken. The
	// request is noted here, so the predictor state is current for the next one.
	task automatic send_request(input gocmv_pkg::sample_t a, input gocmv_pkg::sample_t b,
		input gocmv_pkg::sample_t c, input logic restart);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			samp_if.valid <= 1'b0;
			@(negedge clk);
		end
		samp_if.valid    <= 1'b1;
		samp_if.sample_a <= a;
		samp_if.sample_b <= b;
		samp_if.sample_c <= c;
		samp_if.restart  <= restart;
		do
			@(posedge clk);
		while (!samp_if.ready);
		sb.note_request(a, b, c, restart);
	endtask

	// Sample on channel to_ch whose compensated value equals that of src on
	// channel from_ch; falls back when the match would leave 16 bits.
	function automatic gocmv_pkg::sample_t tie_sample(gocmv_pkg::sample_t src, int from_ch,
		int to_ch, gocmv_pkg::sample_t fallback);
		int want;
		want = int'(src) - sb.offsets[from_ch] + sb.offsets[to_ch];
		if (want >= -32768 && want <= 32767)
			return gocmv_pkg::sample_t'(want);
		return fallback;
	endfunction

	function automatic gocmv_pkg::sample_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return gocmv_pkg::sample_t'(-32768);
			1: return gocmv_pkg::sample_t'(32767);
			2: return gocmv_pkg::sample_t'(0);
			default: return gocmv_pkg::sample_t'(-1);
		endcase
	endfunction

	function automatic gocmv_pkg::sample_t clamp_sample(int v);
		if (v > 32767)
			return gocmv_pkg::sample_t'(32767);
		if (v < -32768)
			return gocmv_pkg::sample_t'(-32768);
		return gocmv_pkg::sample_t'(v);
	endfunction

	// Calibrated-triple content: mostly random, some extremes, some ties.
	task automatic make_vote_triple(output gocmv_pkg::sample_t a,
		output gocmv_pkg::sample_t b, output gocmv_pkg::sample_t c);
		a = gocmv_pkg::sample_t'($urandom);
		b = gocmv_pkg::sample_t'($urandom);
		c = gocmv_pkg::sample_t'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				a = pick_extreme();
				b = pick_extreme();
				c = pick_extreme();
			end
			6: b = tie_sample(a, 0, 1, b);
			7: c = tie_sample(b, 1, 2, c);
			8: begin
				b = tie_sample(a, 0, 1, b);
				c = tie_sample(a, 0, 2, c);
			end
			9: c = tie_sample(a, 0, 2, c);
			default: ;
		endcase
	endtask

	initial begin
		int                 sent;
		int                 style;
		int                 run_len;
		int                 base[3];
		bit                 skip_restart;
		logic               rst;
		gocmv_pkg::sample_t s[3];

		arst_n           = 1'b0;
		quiet            = 1'b0;
		samp_if.valid    = 1'b0;
		samp_if.sample_a = '0;
		samp_if.sample_b = '0;
		samp_if.sample_c = '0;
		samp_if.restart  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: offsets at both extremes on a and b; channel c sums to -39,
		// which must truncate toward zero to an offset of -1.
		for (int i = 0; i < CAL_N; i++)
			send_request(gocmv_pkg::sample_t'(-32768), gocmv_pkg::sample_t'(32767),
				(i == 7) ? gocmv_pkg::sample_t'(-39) : gocmv_pkg::sample_t'(0), i == 0);
		// widest swings on both sides
		send_request(gocmv_pkg::sample_t'(32767), gocmv_pkg::sample_t'(-32768),
			gocmv_pkg::sample_t'(0), 1'b0);
		// two-way tie at zero
		send_request(gocmv_pkg::sample_t'(-32768), gocmv_pkg::sample_t'(32767),
			gocmv_pkg::sample_t'(32767), 1'b0);
		// three-way tie
		send_request(gocmv_pkg::sample_t'(-32768), gocmv_pkg::sample_t'(32767),
			gocmv_pkg::sample_t'(-1), 1'b0);
		// two-way ties at the low and the high value
		send_request(gocmv_pkg::sample_t'(0), gocmv_pkg::sample_t'(0),
			gocmv_pkg::sample_t'(-32768), 1'b0);
		send_request(gocmv_pkg::sample_t'(0), gocmv_pkg::sample_t'(0),
			gocmv_pkg::sample_t'(32767), 1'b0);

		// Random: mostly a full calibration followed by a run of voted triples;
		// now and then a missing or stray restart breaks the pattern.
		sent = 0;
		while (sent < RAND_ITEMS) begin
			style = $urandom_range(0, 3);
			for (int k = 0; k < 3; k++) begin
				if (style == 1)
					base[k] = $urandom_range(0, 1) ? 32767 : -32768;
				else
					base[k] = int'(gocmv_pkg::sample_t'($urandom));
			end
			skip_restart = ($urandom_range(0, 19) == 0);
			for (int i = 0; i < CAL_N; i++) begin
				for (int k = 0; k < 3; k++) begin
					case (style)
						1: s[k] = gocmv_pkg::sample_t'(base[k]);
						2: s[k] = clamp_sample(base[k] + $urandom_range(0, 16) - 8);
						3: s[k] = $urandom_range(0, 1) ? pick_extreme()
							: gocmv_pkg::sample_t'($urandom);
						default: s[k] = gocmv_pkg::sample_t'($urandom);
					endcase
				end
				rst = (i == 0 && !skip_restart) || ($urandom_range(0, 49) == 0);
				quiet = (sent >= 700 && sent < 1000);
				send_request(s[0], s[1], s[2], rst);
				sent++;
			end
			run_len = $urandom_range(3, 60);
			for (int i = 0; i < run_len; i++) begin
				make_vote_triple(s[0], s[1], s[2]);
				rst = ($urandom_range(0, 99) == 0);
				quiet = (sent >= 700 && sent < 1000);
				send_request(s[0], s[1], s[2], rst);
				sent++;
			end
		end
		quiet = 1'b0;
		@(negedge clk);
		samp_if.valid <= 1'b0;

		// drain: every expected vote back, then wait out DRAIN_WAIT to catch strays
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d expected results never arrived", sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== gyro_offset_calibrate_median_vote_core.f =====
rtl/gocmv_pkg.sv
rtl/gocmv_ifs.sv
rtl/gocmv_lane.sv
rtl/gocmv_median.sv
rtl/gyro_offset_calibrate_median_vote_core.sv
sim/gyro_offset_calibrate_median_vote_core_tb.sv
